>>> sv/timestamped_value_line_parser_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timestamped value line parser
// Shared property wrappers; all of them sample on clk and are held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMPED_VALUE_LINE_PARSER_CORE_DEFINES_SVH
`define TIMESTAMPED_VALUE_LINE_PARSER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define TVLP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tvlp assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define TVLP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tvlp assertion failed");
`else
`define TVLP_ASSERT_NOW(label, ante, cons)
`define TVLP_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> sv/tvlp_pkg.sv
// ----------------------------------------------------------------------------
// Timestamped value line parser package
// Types, character codes, status codes and limits shared by the parser files.
// ----------------------------------------------------------------------------
package tvlp_pkg;

    // Default limits, handed down through the top level parameters.
    localparam int MAX_VALUES_DEFAULT       = 16;
    localparam int STAMP_MAX_DIGITS_DEFAULT = 20;
    localparam int VALUE_MAX_DIGITS_DEFAULT = 5;

    localparam logic [4:0] VALUES_EXPECTED_RESET = 5'd16;

    localparam logic [62:0] STAMP_SAT = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [13:0] VALUE_SAT = 14'h3FFF;

    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_NINE     = 8'd57;

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Result queue depth; a power of two so the pointers wrap by themselves.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_STAMP,
        PH_VALUES,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_START,
        ST_BAD_STAMP_CHAR,
        ST_STAMP_UNCLOSED,
        ST_BAD_VALUE_CHAR,
        ST_STAMP_TOO_LONG,
        ST_VALUE_TOO_LONG
    } status_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  value_index;
        logic [13:0] value;
        logic [62:0] timestamp;
        logic [4:0]  value_count;
        logic [2:0]  status;
        logic        last;
    } result_t;

    // What the parser hands to the result queue for one byte.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    function automatic result_t make_value(logic [3:0] idx, logic [13:0] val);
        result_t r;
        r             = '0;
        r.kind        = KIND_VALUE;
        r.value_index = idx;
        r.value       = val;
        return r;
    endfunction

    function automatic result_t make_report(logic [62:0] ts, logic [4:0] cnt,
                                            status_t st);
        result_t r;
        r             = '0;
        r.kind        = KIND_REPORT;
        r.timestamp   = ts;
        r.value_count = cnt;
        r.status      = st;
        return r;
    endfunction

endpackage

>>> sv/tvlp_interfaces.sv
// ----------------------------------------------------------------------------
// Timestamped value line parser channels
// Valid/ready interfaces for the byte input, the result output and the
// configuration write channel.
// ----------------------------------------------------------------------------
interface tvlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tvlp_result_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  value_index;
    logic [13:0] value;
    logic [62:0] timestamp;
    logic [4:0]  value_count;
    logic [2:0]  status;
    logic        last;

    modport source (output valid, output kind, output value_index, output value,
                    output timestamp, output value_count, output status,
                    output last, input ready);
    modport sink (input valid, input kind, input value_index, input value,
                  input timestamp, input value_count, input status,
                  input last, output ready);
endinterface

interface tvlp_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] values_expected;

    modport source (output valid, output values_expected, input ready);
    modport sink (input valid, input values_expected, output ready);
endinterface

>>> sv/tvlp_parser.sv
// ----------------------------------------------------------------------------
// Line parser state machine
// Decodes one byte per fire, updates the parse state and produces up to two
// results for that byte.
// ----------------------------------------------------------------------------
`include "timestamped_value_line_parser_core_defines.svh"

module tvlp_parser #(
    parameter int MAX_VALUES       = tvlp_pkg::MAX_VALUES_DEFAULT,
    parameter int STAMP_MAX_DIGITS = tvlp_pkg::STAMP_MAX_DIGITS_DEFAULT,
    parameter int VALUE_MAX_DIGITS = tvlp_pkg::VALUE_MAX_DIGITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic [4:0]        values_expected,
    output tvlp_pkg::push_t   push
);

    localparam int SEEN_W = $clog2(MAX_VALUES + 1);
    localparam int CNT_W  = (SEEN_W > 5) ? SEEN_W : 5;
    localparam int SD_W   = $clog2(STAMP_MAX_DIGITS + 1);
    localparam int VD_W   = $clog2(VALUE_MAX_DIGITS + 1);

    tvlp_pkg::phase_t    phase_reg, phase_next;
    logic [62:0]         stamp_accum_reg, stamp_accum_next;
    logic [SD_W-1:0]     stamp_digits_reg, stamp_digits_next;
    logic [13:0]         value_accum_reg, value_accum_next;
    logic [VD_W-1:0]     value_digits_reg, value_digits_next;
    logic [SEEN_W-1:0]   values_seen_reg, values_seen_next;

    logic        is_digit, is_lb, is_rb, is_comma;
    logic [3:0]  digit_val;
    logic [66:0] stamp_wide;
    logic [62:0] stamp_acc_sat;
    logic [17:0] value_wide;
    logic [13:0] value_acc_sat;
    logic [SD_W-1:0]   stamp_digits_inc;
    logic [VD_W-1:0]   value_digits_inc;
    logic              stamp_too_long, value_too_long;
    logic [SEEN_W-1:0] seen_inc;
    logic [CNT_W-1:0]  seen_ext, seen_inc_ext, cfg_ext, expect_val;
    logic              line_full;

    // Character classes.
    assign is_digit  = (data_byte >= tvlp_pkg::CH_ZERO) && (data_byte <= tvlp_pkg::CH_NINE);
    assign is_lb     = (data_byte == tvlp_pkg::CH_LBRACKET);
    assign is_rb     = (data_byte == tvlp_pkg::CH_RBRACKET);
    assign is_comma  = (data_byte == tvlp_pkg::CH_COMMA);
    assign digit_val = data_byte[3:0];

    // Multiply by ten as two shifts; the saturation test is 10*a + d > max.
    assign stamp_wide    = 67'({stamp_accum_reg, 3'b000}) + 67'({stamp_accum_reg, 1'b0})
                         + 67'(digit_val);
    assign stamp_acc_sat = (stamp_wide > 67'(tvlp_pkg::STAMP_SAT))
                         ? tvlp_pkg::STAMP_SAT : stamp_wide[62:0];
    assign value_wide    = 18'({value_accum_reg, 3'b000}) + 18'({value_accum_reg, 1'b0})
                         + 18'(digit_val);
    assign value_acc_sat = (value_wide > 18'(tvlp_pkg::VALUE_SAT))
                         ? tvlp_pkg::VALUE_SAT : value_wide[13:0];

    assign stamp_digits_inc = stamp_digits_reg + SD_W'(1);
    assign value_digits_inc = value_digits_reg + VD_W'(1);
    assign stamp_too_long   = (stamp_digits_inc >= SD_W'(STAMP_MAX_DIGITS));
    assign value_too_long   = (value_digits_inc >= VD_W'(VALUE_MAX_DIGITS));

    // Values per line, clamped into one to MAX_VALUES.
    assign cfg_ext    = CNT_W'(values_expected);
    assign expect_val = (cfg_ext == '0) ? CNT_W'(1)
                      : (cfg_ext > CNT_W'(MAX_VALUES)) ? CNT_W'(MAX_VALUES) : cfg_ext;
    assign seen_inc     = values_seen_reg + SEEN_W'(1);
    assign seen_ext     = CNT_W'(values_seen_reg);
    assign seen_inc_ext = CNT_W'(seen_inc);
    assign line_full    = (seen_inc_ext >= expect_val);

    // Next state.
    always_comb
    begin
        phase_next        = phase_reg;
        stamp_accum_next  = stamp_accum_reg;
        stamp_digits_next = stamp_digits_reg;
        value_accum_next  = value_accum_reg;
        value_digits_next = value_digits_reg;
        values_seen_next  = values_seen_reg;
        unique case (phase_reg) inside
            tvlp_pkg::PH_STAMP:
            begin
                if (is_rb)
                begin
                    phase_next        = tvlp_pkg::PH_VALUES;
                    value_accum_next  = '0;
                    value_digits_next = '0;
                    values_seen_next  = '0;
                end
                else if (is_digit)
                begin
                    stamp_digits_next = stamp_digits_inc;
                    if (stamp_too_long)
                        phase_next = tvlp_pkg::PH_SKIP;
                    else
                        stamp_accum_next = stamp_acc_sat;
                end
                else
                begin
                    phase_next = tvlp_pkg::PH_SKIP;
                end
            end
            tvlp_pkg::PH_VALUES:
            begin
                if (is_digit)
                begin
                    value_digits_next = value_digits_inc;
                    if (value_too_long)
                        phase_next = tvlp_pkg::PH_SKIP;
                    else
                        value_accum_next = value_acc_sat;
                end
                else if (is_comma || is_lb)
                begin
                    values_seen_next  = seen_inc;
                    value_accum_next  = '0;
                    value_digits_next = '0;
                    if (line_full || is_lb || last_byte)
                    begin
                        if (is_lb && !last_byte)
                        begin
                            phase_next        = tvlp_pkg::PH_STAMP;
                            stamp_accum_next  = '0;
                            stamp_digits_next = '0;
                            values_seen_next  = '0;
                        end
                        else
                        begin
                            phase_next = tvlp_pkg::PH_SKIP;
                        end
                    end
                end
                else
                begin
                    phase_next = tvlp_pkg::PH_SKIP;
                end
            end
            tvlp_pkg::PH_SEARCH, tvlp_pkg::PH_SKIP:
            begin
                if (is_lb)
                begin
                    phase_next        = tvlp_pkg::PH_STAMP;
                    stamp_accum_next  = '0;
                    stamp_digits_next = '0;
                    value_accum_next  = '0;
                    value_digits_next = '0;
                    values_seen_next  = '0;
                end
            end
        endcase
        // Every buffer end sends the parser back to looking for a bracket.
        if (last_byte)
            phase_next = tvlp_pkg::PH_SEARCH;
    end

    // Results for the current byte.
    always_comb
    begin
        push = '0;
        unique case (phase_reg) inside
            tvlp_pkg::PH_STAMP:
            begin
                if (is_rb)
                begin
                    if (last_byte)
                    begin
                        push.count = 2'd1;
                        push.first = tvlp_pkg::make_report(stamp_accum_reg, 5'd0,
                                                           tvlp_pkg::ST_OK);
                    end
                end
                else if (is_digit)
                begin
                    if (stamp_too_long)
                    begin
                        push.count = 2'd1;
                        push.first = tvlp_pkg::make_report('0, 5'd0,
                                                           tvlp_pkg::ST_STAMP_TOO_LONG);
                    end
                    else if (last_byte)
                    begin
                        push.count = 2'd1;
                        push.first = tvlp_pkg::make_report('0, 5'd0,
                                                           tvlp_pkg::ST_STAMP_UNCLOSED);
                    end
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = tvlp_pkg::make_report('0, 5'd0,
                                                       tvlp_pkg::ST_BAD_STAMP_CHAR);
                end
            end
            tvlp_pkg::PH_VALUES:
            begin
                if (is_digit)
                begin
                    if (value_too_long)
                    begin
                        push.count = 2'd1;
                        push.first = tvlp_pkg::make_report(stamp_accum_reg, seen_ext[4:0],
                                                           tvlp_pkg::ST_VALUE_TOO_LONG);
                    end
                    else if (last_byte)
                    begin
                        push.count = 2'd1;
                        push.first = tvlp_pkg::make_report(stamp_accum_reg, seen_ext[4:0],
                                                           tvlp_pkg::ST_OK);
                    end
                end
                else if (is_comma || is_lb)
                begin
                    push.count = 2'd1;
                    push.first = tvlp_pkg::make_value(seen_ext[3:0], value_accum_reg);
                    if (line_full || is_lb || last_byte)
                    begin
                        push.count  = 2'd2;
                        push.second = tvlp_pkg::make_report(stamp_accum_reg,
                                                            seen_inc_ext[4:0],
                                                            tvlp_pkg::ST_OK);
                    end
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = tvlp_pkg::make_report(stamp_accum_reg, seen_ext[4:0],
                                                       tvlp_pkg::ST_BAD_VALUE_CHAR);
                end
            end
            tvlp_pkg::PH_SEARCH, tvlp_pkg::PH_SKIP:
            begin
                if (is_lb)
                begin
                    if (last_byte)
                    begin
                        push.count = 2'd1;
                        push.first = tvlp_pkg::make_report('0, 5'd0,
                                                           tvlp_pkg::ST_STAMP_UNCLOSED);
                    end
                end
                else if (last_byte && (phase_reg == tvlp_pkg::PH_SEARCH))
                begin
                    push.count = 2'd1;
                    push.first = tvlp_pkg::make_report('0, 5'd0, tvlp_pkg::ST_NO_START);
                end
            end
        endcase
        push.first.last  = (push.count == 2'd1);
        push.second.last = (push.count == 2'd2);
        if (!fire)
            push.count = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= tvlp_pkg::PH_SEARCH;
            stamp_accum_reg  <= '0;
            stamp_digits_reg <= '0;
            value_accum_reg  <= '0;
            value_digits_reg <= '0;
            values_seen_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            stamp_accum_reg  <= stamp_accum_next;
            stamp_digits_reg <= stamp_digits_next;
            value_accum_reg  <= value_accum_next;
            value_digits_reg <= value_digits_next;
            values_seen_reg  <= values_seen_next;
        end
    end

    // A pair of results is always a value followed by the report closing its line.
    `TVLP_ASSERT_NOW(a_pair_order, push.count == 2'd2,
        push.first.kind == tvlp_pkg::KIND_VALUE && push.second.kind == tvlp_pkg::KIND_REPORT)
    // A buffer end always leaves the parser searching.
    `TVLP_ASSERT_NEXT(a_last_to_search, fire && last_byte, phase_reg == tvlp_pkg::PH_SEARCH)
    // The value counter never passes the largest line length.
    `TVLP_ASSERT_NOW(a_seen_bound, 1'b1, CNT_W'(values_seen_reg) <= CNT_W'(MAX_VALUES))

endmodule

>>> sv/tvlp_result_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results a cycle from the parser
// and hands them out one beat at a time.
// ----------------------------------------------------------------------------
`include "timestamped_value_line_parser_core_defines.svh"

module tvlp_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvlp_pkg::push_t      push,
    output logic                 room,
    tvlp_result_if.source        result_out
);

    localparam int DEPTH = tvlp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    tvlp_pkg::result_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;
    tvlp_pkg::result_t head;

    assign pop  = result_out.valid && result_out.ready;
    // Space for a full pair, so the parser never has to hold a byte halfway.
    assign room = (count_reg <= CNT_W'(DEPTH - 2));

    assign head                   = entries[rd_ptr_reg];
    assign result_out.valid       = (count_reg != '0);
    assign result_out.kind        = head.kind;
    assign result_out.value_index = head.value_index;
    assign result_out.value       = head.value;
    assign result_out.timestamp   = head.timestamp;
    assign result_out.value_count = head.value_count;
    assign result_out.status      = head.status;
    assign result_out.last        = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            entries[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            entries[wr_ptr_reg + PTR_W'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The fill level stays within the queue.
    `TVLP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    // The fill level moves by exactly the pushes minus the pop.
    `TVLP_ASSERT_NEXT(a_count_track, 1'b1,
        count_reg == $past(count_reg) + CNT_W'($past(push.count)) - CNT_W'($past(pop)))

endmodule

>>> sv/timestamped_value_line_parser_core.sv
// ----------------------------------------------------------------------------
// Timestamped value line parser core
// Parses a byte stream of "[stamp]v,v,v" lines into value and report results.
// ----------------------------------------------------------------------------
//
//  Channel     Role   Beat carries
//  ---------   ----   ------------------------------------------------------
//  byte_in     sink   data_byte, last_byte
//  result_out  source kind, value_index, value, timestamp, value_count,
//                     status, last
//  cfg         sink   values_expected (always ready)
//
// While the queue has room, one byte per cycle enters the input register; the
// parser decodes it and writes its zero, one or two results into a four-entry
// queue. A byte with two results costs two output beats. The stage advances
// only while the queue has room for a pair, so a stalled output closes
// byte_in.ready once the queue holds more than two results. Reset (rst_n,
// asynchronous, active low): searching, queue empty.
//
module timestamped_value_line_parser_core #(
    parameter int MAX_VALUES       = tvlp_pkg::MAX_VALUES_DEFAULT,
    parameter int STAMP_MAX_DIGITS = tvlp_pkg::STAMP_MAX_DIGITS_DEFAULT,
    parameter int VALUE_MAX_DIGITS = tvlp_pkg::VALUE_MAX_DIGITS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    tvlp_byte_if.sink      byte_in,
    tvlp_result_if.source  result_out,
    tvlp_cfg_if.sink       cfg
);

    // Configuration register, reset to sixteen; the host is to write it only while
    // no beat is in flight, which the block itself does not enforce.
    logic [4:0] values_expected_reg;

    // Input register stage.
    logic       stage_valid_reg;
    logic [7:0] stage_byte_reg;
    logic       stage_last_reg;

    logic            queue_room;
    logic            advance;
    logic            take;
    tvlp_pkg::push_t push;

    assign cfg.ready = 1'b1;

    // The staged byte moves into the parser whenever the queue can absorb a
    // pair, and the stage refills in the same cycle.
    assign advance       = stage_valid_reg && queue_room;
    assign byte_in.ready = !stage_valid_reg || advance;
    assign take          = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            values_expected_reg <= tvlp_pkg::VALUES_EXPECTED_RESET;
        else if (cfg.valid && cfg.ready)
            values_expected_reg <= cfg.values_expected;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (byte_in.ready)
            stage_valid_reg <= byte_in.valid;
    end

    // Payload of the stage needs no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_byte_reg <= byte_in.data_byte;
            stage_last_reg <= byte_in.last_byte;
        end
    end

    tvlp_parser #(
        .MAX_VALUES       (MAX_VALUES),
        .STAMP_MAX_DIGITS (STAMP_MAX_DIGITS),
        .VALUE_MAX_DIGITS (VALUE_MAX_DIGITS)
    ) u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .fire            (advance),
        .data_byte       (stage_byte_reg),
        .last_byte       (stage_last_reg),
        .values_expected (values_expected_reg),
        .push            (push)
    );

    tvlp_result_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (queue_room),
        .result_out (result_out)
    );

endmodule
